>>> rtl/core/shh_pkg.sv
package shh_pkg;

  // Histogram geometry and counter width.
  localparam int MODULES    = 8192;
  localparam int STRIPS     = 768;
  localparam int COUNT_BITS = 32;

  // Widths fixed by the request and result fields.
  localparam int MODE_W   = 2;
  localparam int MODIDX_W = 13;
  localparam int STRIP_IN_W = 10;
  localparam int SIZE_W   = 10;
  localparam int OUT_W    = 32;

  // Derived storage widths.
  localparam int DEPTH   = MODULES * STRIPS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STRIP_W = (STRIPS > 1) ? $clog2(STRIPS) : 1;
  // Wide enough for first strip plus group size and for STRIPS itself.
  localparam int EXT_W   = 13;
  localparam int MODX_W  = 15;

  typedef enum logic [MODE_W-1:0] {
    MODE_EVENT = 2'd0,
    MODE_GROUP = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GROUP,
    ST_RDREQ,
    ST_RDDATA,
    ST_DONE
  } state_e;

  // One read port and one write port of the bin memory.
  typedef struct packed {
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [COUNT_BITS-1:0] wdata;
  } mem_req_t;

  // Saturating increment of one bin counter.
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + {{(COUNT_BITS-1){1'b0}}, 1'b1};
  endfunction

  // Clamp a bin counter to the 32-bit result field.
  function automatic logic [OUT_W-1:0] clamp_bin(input logic [COUNT_BITS-1:0] v);
    logic [63:0] wide;
    wide = 64'(v);
    if (wide > 64'h0000_0000_FFFF_FFFF) begin
      return {OUT_W{1'b1}};
    end
    return wide[OUT_W-1:0];
  endfunction

endpackage

>>> rtl/core/shh_ram.sv
module shh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/shh_ctrl.sv
module shh_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [shh_pkg::MODE_W-1:0]     mode_i,
  input  logic [shh_pkg::MODIDX_W-1:0]   module_index_i,
  input  logic [shh_pkg::STRIP_IN_W-1:0] first_strip_i,
  input  logic [shh_pkg::SIZE_W-1:0]     group_size_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [shh_pkg::OUT_W-1:0]      bin_count_o,
  output logic [shh_pkg::OUT_W-1:0]      events_seen_o,
  output logic                           clipped_o,
  output shh_pkg::mem_req_t              mem_req_o,
  input  logic [shh_pkg::COUNT_BITS-1:0] mem_rdata_i
);

  import shh_pkg::*;

  localparam logic [EXT_W-1:0]  STRIPS_X  = EXT_W'(STRIPS);
  localparam logic [MODX_W-1:0] MODULES_X = MODX_W'(MODULES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [SIZE_W-1:0]   rd_left_q, rd_left_d;
  logic                pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  logic [OUT_W-1:0]    event_q, event_d;
  logic [STRIP_W-1:0]  strip_q, strip_d;
  logic [ADDR_W-1:0]   base_q, base_d;
  logic [ADDR_W-1:0]   waddr_q, waddr_d;
  logic [OUT_W-1:0]    bin_q, bin_d;
  logic                clip_q, clip_d;
  logic [OUT_W-1:0]    res_bin_q, res_bin_d;
  logic [OUT_W-1:0]    res_evt_q, res_evt_d;
  logic                res_clip_q, res_clip_d;

  logic [EXT_W-1:0]    first_x, size_x, end_x, n_in;
  logic                mod_ok, strip_ok, grp_clip;
  logic [ADDR_W-1:0]   cur_addr;

  // Decode of the incoming request: range checks and in-range strip count.
  always_comb begin
    first_x  = EXT_W'(first_strip_i);
    size_x   = EXT_W'(group_size_i);
    end_x    = first_x + size_x;
    mod_ok   = ({{(MODX_W-MODIDX_W){1'b0}}, module_index_i} < MODULES_X);
    strip_ok = (first_x < STRIPS_X);
    if (!mod_ok || !strip_ok) begin
      n_in = '0;
    end else if (end_x > STRIPS_X) begin
      n_in = STRIPS_X - first_x;
    end else begin
      n_in = size_x;
    end
    grp_clip = (group_size_i != '0) && (!mod_ok || (end_x > STRIPS_X));
  end

  assign cur_addr = base_q + ADDR_W'(strip_q);

  // Next state, memory accesses and result handoff.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    rd_left_d   = rd_left_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    event_d     = event_q;
    strip_d     = strip_q;
    base_d      = base_q;
    waddr_d     = waddr_q;
    bin_d       = bin_q;
    clip_d      = clip_q;
    res_bin_d   = res_bin_q;
    res_evt_d   = res_evt_q;
    res_clip_d  = res_clip_q;
    mem_req_o   = '0;
    in_stall_o  = (state_q != ST_IDLE);

    // The result register empties when the downstream side takes it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_q;
        mem_req_o.wdata = '0;
        clr_d           = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          base_d  = ADDR_W'(ADDR_W'(module_index_i) * ADDR_W'(STRIPS));
          strip_d = STRIP_W'(first_strip_i);
          bin_d   = '0;
          clip_d  = 1'b0;
          case (mode_e'(mode_i))
            MODE_EVENT: begin
              event_d = (event_q == {OUT_W{1'b1}}) ? event_q : event_q + 1'b1;
              state_d = ST_DONE;
            end
            MODE_GROUP: begin
              rd_left_d = SIZE_W'(n_in);
              clip_d    = grp_clip;
              state_d   = ST_GROUP;
            end
            MODE_READ: begin
              state_d = (mod_ok && strip_ok) ? ST_RDREQ : ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      // One strip read per cycle; the previous strip is written back
      // in the same cycle, always at a different address.
      ST_GROUP: begin
        if (pend_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = waddr_q;
          mem_req_o.wdata = sat_inc(mem_rdata_i);
        end
        if (rd_left_q != '0) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = cur_addr;
          waddr_d         = cur_addr;
          strip_d         = strip_q + 1'b1;
          rd_left_d       = rd_left_q - 1'b1;
          pend_d          = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = ST_DONE;
          end
        end
      end

      ST_RDREQ: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = cur_addr;
        state_d         = ST_RDDATA;
      end

      ST_RDDATA: begin
        bin_d   = clamp_bin(mem_rdata_i);
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          res_bin_d   = bin_q;
          res_evt_d   = event_q;
          res_clip_d  = clip_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rd_left_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      event_q     <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rd_left_q   <= rd_left_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      event_q     <= event_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    strip_q    <= strip_d;
    base_q     <= base_d;
    waddr_q    <= waddr_d;
    bin_q      <= bin_d;
    clip_q     <= clip_d;
    res_bin_q  <= res_bin_d;
    res_evt_q  <= res_evt_d;
    res_clip_q <= res_clip_d;
  end

  assign out_valid_o   = out_valid_q;
  assign bin_count_o   = res_bin_q;
  assign events_seen_o = res_evt_q;
  assign clipped_o     = res_clip_q;

  // A read and a write-back in the same cycle never touch the same bin.
  a_no_same_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req_o.re && mem_req_o.we) |-> (mem_req_o.raddr != mem_req_o.waddr))
    else $error("read and write-back hit the same bin");

  // A pending write-back only exists while a group is being processed.
  a_pend_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_GROUP))
    else $error("write-back pending outside group processing");

  // A new result only appears after the handoff state.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result appeared without a finished request");

  // The event counter never decreases.
  a_event_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) |=> (event_q >= $past(event_q)))
    else $error("event counter went backward");

  // No result is presented while the bin memory is being cleared.
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !out_valid_q)
    else $error("result present during clearing pass");

endmodule

>>> rtl/core/strip_hitmap_histogram.sv
// Channel  | Handshake                    | Payload
// ---------+------------------------------+---------------------------------------------
// request  | in_valid_i / in_stall_o      | mode_i, module_index_i, first_strip_i,
//          |                              | group_size_i
// result   | out_valid_o / out_stall_i    | bin_count_o, events_seen_o, clipped_o
//
// One request is processed at a time. An event, an unused mode or a read outside the
// histogram goes straight to the handoff step; an in-range read passes a read request
// step and a read data step first, and a hit group reads its in-range strips in turn,
// each one read-modify-write. After reset the bin memory is cleared one bin per cycle,
// all MODULES*STRIPS (6291456) bins, with in_stall_o held high. A finished result waits
// in the output register; while it is stalled the next request holds in its last step.
module strip_hitmap_histogram (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [shh_pkg::MODE_W-1:0]     mode_i,
  input  logic [shh_pkg::MODIDX_W-1:0]   module_index_i,
  input  logic [shh_pkg::STRIP_IN_W-1:0] first_strip_i,
  input  logic [shh_pkg::SIZE_W-1:0]     group_size_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [shh_pkg::OUT_W-1:0]      bin_count_o,
  output logic [shh_pkg::OUT_W-1:0]      events_seen_o,
  output logic                           clipped_o
);

  import shh_pkg::*;

  mem_req_t              mem_req;
  logic [COUNT_BITS-1:0] mem_rdata;

  // Sequencer: request decode, group loop, event counter and result register.
  shh_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .module_index_i (module_index_i),
    .first_strip_i  (first_strip_i),
    .group_size_i   (group_size_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bin_count_o    (bin_count_o),
    .events_seen_o  (events_seen_o),
    .clipped_o      (clipped_o),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata)
  );

  // Bin counters of all modules.
  shh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_bins (
    .clk_i   (clk_i),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

endmodule

>>> test/tb_strip_hitmap_histogram.sv
`timescale 1ns / 100ps

module tb_strip_hitmap_histogram;
  import shh_pkg::*;

  // The one mode code that the package leaves unnamed.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int unsigned RANDOM_REQUESTS = 1930;
  localparam int unsigned QUIET_START     = 1650;
  localparam int unsigned HOLD_AT         = 900;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned DRAIN_CYCLES    = 50;
  // The clearing pass plus every request at its slowest, taken three times over.
  localparam longint unsigned LIMIT_CYCLES = 3 * (longint'(DEPTH) + 2000 * 800);

  typedef struct packed {
    logic [OUT_W-1:0] bin_count;
    logic [OUT_W-1:0] events_seen;
    logic             clipped;
  } hist_result_t;

  // Bin store, event counter and the queue of results still owed by the block.
  class hitmap_scoreboard;
    logic [COUNT_BITS-1:0] bin_store [int unsigned];
    logic [OUT_W-1:0]      event_total;
    hist_result_t          owed_q[$];
    int unsigned           mismatches;
    int unsigned           checked;

    function new();
      event_total = '0;
      mismatches  = 0;
      checked     = 0;
    endfunction

    // Apply one accepted request to the histogram and queue the result it owes.
    function void note_request(logic [MODE_W-1:0] mode, logic [MODIDX_W-1:0] module_idx,
                               logic [STRIP_IN_W-1:0] first, logic [SIZE_W-1:0] size);
      hist_result_t          res;
      int unsigned           addr;
      int unsigned           strip;
      logic [COUNT_BITS-1:0] cnt;
      logic [63:0]           wide;
      res = '0;
      case (mode)
        MODE_EVENT: begin
          if (event_total != '1) event_total = event_total + 1'b1;
        end
        MODE_GROUP: begin
          if (int'(module_idx) >= MODULES) begin
            res.clipped = (size != '0);
          end else begin
            for (int k = 0; k < int'(size); k++) begin
              strip = int'(first) + k;
              if (strip >= STRIPS) begin
                res.clipped = 1'b1;
              end else begin
                addr = int'(module_idx) * STRIPS + strip;
                cnt = bin_store.exists(addr) ? bin_store[addr] : '0;
                if (cnt != '1) cnt = cnt + 1'b1;
                bin_store[addr] = cnt;
              end
            end
          end
        end
        MODE_READ: begin
          if (int'(module_idx) < MODULES && int'(first) < STRIPS) begin
            addr = int'(module_idx) * STRIPS + int'(first);
            wide = bin_store.exists(addr) ? 64'(bin_store[addr]) : 64'd0;
            res.bin_count = (wide > 64'h0000_0000_FFFF_FFFF) ? '1 : wide[OUT_W-1:0];
          end
        end
        default: begin
        end
      endcase
      res.events_seen = event_total;
      owed_q = {owed_q, res};
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    // Compare one accepted result with the oldest owed result.
    task check_result(logic [OUT_W-1:0] bin_count, logic [OUT_W-1:0] events_seen,
                      logic clipped);
      hist_result_t want;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed (bin %0d events %0d clip %0b)",
                                  bin_count, events_seen, clipped));
      end else begin
        want = owed_q.pop_front();
        checked++;
        if (bin_count !== want.bin_count)
          report_mismatch($sformatf("bin_count %0d, want %0d", bin_count, want.bin_count));
        if (events_seen !== want.events_seen)
          report_mismatch($sformatf("events_seen %0d, want %0d", events_seen,
                                    want.events_seen));
        if (clipped !== want.clipped)
          report_mismatch($sformatf("clipped %0b, want %0b", clipped, want.clipped));
      end
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [MODE_W-1:0]     mode_i;
  logic [MODIDX_W-1:0]   module_index_i;
  logic [STRIP_IN_W-1:0] first_strip_i;
  logic [SIZE_W-1:0]     group_size_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [OUT_W-1:0]      bin_count_o;
  logic [OUT_W-1:0]      events_seen_o;
  logic                  clipped_o;

  hitmap_scoreboard sb;
  bit               idle_on;
  int unsigned      holds_asked;
  int unsigned      holds_served;
  int unsigned      hold_left;
  int unsigned      stall_burst;
  int unsigned      n_events, n_groups, n_reads, n_unused;
  longint unsigned  cycles;
  logic [MODIDX_W-1:0] hot_modules [4];

  strip_hitmap_histogram dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .module_index_i (module_index_i),
    .first_strip_i  (first_strip_i),
    .group_size_i   (group_size_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bin_count_o    (bin_count_o),
    .events_seen_o  (events_seen_o),
    .clipped_o      (clipped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Cycle counter with a hard stop.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results owed.", cycles, sb.owed_q.size());
      $display("tb_strip_hitmap_histogram: errors");
      $finish;
    end
  end

  // Result monitor: every accepted result is checked against the oldest owed one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(bin_count_o, events_seen_o, clipped_o);
  end

  // Result receiver: random stall bursts, plus long hold-offs on request.
  always @(negedge clk_i) begin
    if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_burst > 0) begin
      stall_burst--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(7) == 0) begin
      stall_burst = $urandom_range(8);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic [MODIDX_W-1:0] module_idx,
                              input logic [STRIP_IN_W-1:0] first,
                              input logic [SIZE_W-1:0] size);
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    module_index_i <= module_idx;
    first_strip_i  <= first;
    group_size_i   <= size;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(mode, module_idx, first, size);
    case (mode)
      MODE_EVENT: n_events++;
      MODE_GROUP: n_groups++;
      MODE_READ:  n_reads++;
      default:    n_unused++;
    endcase
  endtask

  // When idling is on, sometimes drop valid for a random burst.
  task automatic sender_gap();
    if (idle_on && $urandom_range(5) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(8)) @(negedge clk_i);
    end
  endtask

  // Random request: mostly hot modules and low strips so that reads find counts.
  task automatic random_request();
    int unsigned           pick;
    logic [MODIDX_W-1:0]   module_idx;
    logic [STRIP_IN_W-1:0] first;
    logic [SIZE_W-1:0]     size;
    pick = $urandom_range(99);
    if ($urandom_range(4) != 0) module_idx = hot_modules[2'($urandom_range(3))];
    else module_idx = MODIDX_W'($urandom_range(MODULES - 1));
    if ($urandom_range(9) == 0) first = STRIP_IN_W'($urandom_range(1023));
    else if ($urandom_range(2) == 0) first = STRIP_IN_W'($urandom_range(STRIPS - 1));
    else first = STRIP_IN_W'($urandom_range(48));
    size = SIZE_W'($urandom_range(1023));
    if (pick < 15) begin
      send_request(MODE_EVENT, module_idx, first, size);
    end else if (pick < 57) begin
      // Typical groups are a few strips long; a long one only now and then.
      if ($urandom_range(99) == 0) size = SIZE_W'($urandom_range(1023));
      else if ($urandom_range(6) == 0) size = SIZE_W'($urandom_range(9, 64));
      else size = SIZE_W'($urandom_range(8));
      send_request(MODE_GROUP, module_idx, first, size);
    end else if (pick < 96) begin
      send_request(MODE_READ, module_idx, first, size);
    end else begin
      send_request(MODE_UNUSED, module_idx, first, size);
    end
  endtask

  initial begin
    sb = new();
    hot_modules[0] = '0;
    hot_modules[1] = 13'd5;
    hot_modules[2] = 13'd4096;
    hot_modules[3] = '1;
    idle_on        = 1'b1;
    holds_asked    = 0;
    holds_served   = 0;
    hold_left      = 0;
    stall_burst    = 0;
    n_events = 0;
    n_groups = 0;
    n_reads  = 0;
    n_unused = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_stall_i    = 1'b0;
    mode_i         = MODE_EVENT;
    module_index_i = '0;
    first_strip_i  = '0;
    group_size_i   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed requests; the first one waits out the clearing pass.
    send_request(MODE_EVENT, '0, '0, '0);
    send_request(MODE_GROUP, '0, '0, 10'd1);
    send_request(MODE_READ, '0, '0, '0);
    // Last strip of the last module, then a group running past the last bin.
    send_request(MODE_GROUP, '1, 10'd767, 10'd1);
    send_request(MODE_GROUP, '1, 10'd760, 10'd20);
    send_request(MODE_READ, '1, 10'd767, '1);
    send_request(MODE_READ, '1, 10'd760, '0);
    // An empty group changes nothing and does not clip.
    send_request(MODE_GROUP, '0, '0, '0);
    send_request(MODE_READ, '0, '0, '0);
    // A full row, then a group that lies wholly past the last bin.
    send_request(MODE_GROUP, 13'd5, '0, 10'd768);
    send_request(MODE_READ, 13'd5, 10'd767, '0);
    send_request(MODE_GROUP, 13'd5, '1, '1);
    send_request(MODE_GROUP, 13'd5, 10'd768, 10'd3);
    // Reads past the last bin return zero.
    send_request(MODE_READ, 13'd5, 10'd768, '0);
    send_request(MODE_READ, 13'd5, '1, '1);
    // The unused mode leaves everything as it was.
    send_request(MODE_UNUSED, 13'd5, '0, 10'd17);
    send_request(MODE_READ, 13'd5, '0, '0);
    send_request(MODE_EVENT, '1, '1, '1);
    send_request(MODE_GROUP, 13'h0AAA, 10'h155, 10'h2AA);
    send_request(MODE_GROUP, 13'h1555, 10'h2AA, 10'h155);
    send_request(MODE_READ, 13'h0AAA, 10'd600, 10'h155);
    send_request(MODE_READ, 13'h1555, 10'd700, 10'h2AA);
    send_request(MODE_UNUSED, '1, '1, '1);

    // Random requests, with idling switched on and off in segments.
    for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 100 == 0) idle_on = (i < QUIET_START) && ($urandom_range(3) != 0);
      if (i == HOLD_AT) holds_asked++;
      random_request();
      sender_gap();
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain: wait for every owed result, then keep watching for stray ones.
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests: %0d events, %0d hit groups, %0d reads, %0d unused-mode.",
             n_events + n_groups + n_reads + n_unused, n_events, n_groups, n_reads, n_unused);
    $display("Checked %0d results with %0d mismatches over %0d cycles.",
             sb.checked, sb.mismatches, cycles);
    if (sb.mismatches == 0) begin
      $display("tb_strip_hitmap_histogram: clean");
    end else begin
      $display("tb_strip_hitmap_histogram: errors");
    end
    $finish;
  end

endmodule

>>> strip_hitmap_histogram.f
rtl/core/shh_pkg.sv
rtl/core/shh_ram.sv
rtl/core/shh_ctrl.sv
rtl/core/strip_hitmap_histogram.sv
test/tb_strip_hitmap_histogram.sv
